### hdl/text_console_cursor_controller_unit_defines.svh
// ----------------------------------------------------------------------------
// Console cursor controller assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_CONTROLLER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_CONTROLLER_UNIT_DEFINES_SVH

// Condition must hold at every clock edge outside reset
`define TCCC_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent in a cycle implies consequent in the next
`define TCCC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/tccc_pkg.sv
// ----------------------------------------------------------------------------
// Console cursor controller package
// Codes, character constants and the result queue entry type.
// ----------------------------------------------------------------------------
package tccc_pkg;

   // Request actions
   localparam logic [1:0] ACT_PUT_CHAR   = 2'd0;
   localparam logic [1:0] ACT_SET_CURSOR = 2'd1;
   localparam logic [1:0] ACT_CLEAR      = 2'd2;
   localparam logic [1:0] ACT_RESERVED   = 2'd3;

   // Result commands
   typedef enum logic [1:0] {
      CMD_NONE   = 2'd0,
      CMD_DRAW   = 2'd1,
      CMD_SCROLL = 2'd2,
      CMD_CLEAR  = 2'd3
   } command_type;

   // Control characters
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   // Tab stops fall on multiples of four
   localparam logic [8:0] TAB_STEP = 9'd4;
   localparam logic [8:0] TAB_MASK = ~9'd3;

   // Grid limits
   localparam logic [8:0] GRID_MIN = 9'd1;
   localparam logic [8:0] GRID_MAX = 9'd256;

   // Configuration register indexes
   localparam logic [1:0] REG_COLUMNS = 2'd0;
   localparam logic [1:0] REG_ROWS    = 2'd1;
   localparam logic [1:0] REG_FG      = 2'd2;
   localparam logic [1:0] REG_BG      = 2'd3;

   // Register reset values
   localparam logic [8:0]  COLUMNS_RESET = 9'd80;
   localparam logic [8:0]  ROWS_RESET    = 9'd25;
   localparam logic [31:0] FG_RESET      = 32'h0000_0000;
   localparam logic [31:0] BG_RESET      = 32'h00FF_FFFF;

   // Result queue: room for two transactions' worth of results
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = PTR_W + 1;

   // One result transaction
   typedef struct packed {
      command_type command;
      logic [7:0]  glyph;
      logic [7:0]  cell_col;
      logic [7:0]  cell_row;
      logic [31:0] draw_fg;
      logic [31:0] draw_bg;
      logic        echo_valid;
      logic [7:0]  echo_byte;
      logic [7:0]  cursor_col_now;
      logic [7:0]  cursor_row_now;
      logic        last;
   } rsp_entry_type;

endpackage

### hdl/text_console_cursor_controller_unit.sv
// ----------------------------------------------------------------------------
// Text console cursor controller
// Tracks the cursor on a text grid and turns put-character, set-cursor and
// clear requests into draw, scroll and clear commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request per transaction (action, character, target
//   position); it is taken when req_valid is high and req_stall is low.
//   rsp_* carries the resulting commands, one or two per request, with
//   rsp_last marking the final one; it moves when rsp_valid is high and
//   rsp_stall is low. csr_* writes the grid size and colours while idle;
//   the user must keep to that, as the block does not enforce it. The
//   whole cursor update is done in the cycle a request is taken and its
//   results are written into a four-entry result queue, from whose head
//   they are offered. Throughput is one request per cycle for single-result
//   requests while req_stall is low; a put character that both draws and
//   scrolls yields two results, so the output port sets the sustained rate.
//   req_stall rises only when the queue has fewer than two free entries; it
//   does not follow rsp_stall combinationally, so requests keep flowing
//   while a finished result waits to be taken.
//   Reset (synchronous) empties the queue, puts the cursor at the top left
//   and restores an 80 by 25 grid with black on white colours.
// ----------------------------------------------------------------------------
`include "text_console_cursor_controller_unit_defines.svh"

module text_console_cursor_controller_unit
   import tccc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // Configuration write port
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   // Request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [7:0]         req_char_code,
   input  logic signed [15:0] req_target_col,
   input  logic signed [15:0] req_target_row,
   // Result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_command,
   output logic [7:0]         rsp_glyph,
   output logic [7:0]         rsp_cell_col,
   output logic [7:0]         rsp_cell_row,
   output logic [31:0]        rsp_draw_fg,
   output logic [31:0]        rsp_draw_bg,
   output logic               rsp_echo_valid,
   output logic [7:0]         rsp_echo_byte,
   output logic [7:0]         rsp_cursor_col_now,
   output logic [7:0]         rsp_cursor_row_now,
   output logic               rsp_last
);

   // Configuration registers
   logic [8:0]  columns_ff;
   logic [8:0]  rows_ff;
   logic [31:0] fg_ff;
   logic [31:0] bg_ff;

   // Cursor state
   logic [7:0] cursor_col_ff, cursor_col_in;
   logic [7:0] cursor_row_ff, cursor_row_in;

   // Result queue
   rsp_entry_type         fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic          req_fire;
   logic          rsp_fire;
   logic [8:0]    ncols;
   logic [8:0]    nrows;
   rsp_entry_type first_entry;
   rsp_entry_type second_entry;
   logic          push_two;
   rsp_entry_type head;

   // Check terms
   logic          clear_fire;
   logic          put_fire;
   logic          cursor_home;
   logic          cursor_on_grid;

   // Clamp a requested position onto a grid of n cells
   function automatic logic [7:0] clamp_pos(input logic signed [15:0] v,
                                            input logic [8:0] n);
      logic [8:0] n_m1;
      n_m1 = n - 9'd1;
      if (v[15])
         clamp_pos = 8'd0;
      else if ({1'b0, v[14:0]} >= {7'd0, n})
         clamp_pos = n_m1[7:0];
      else
         clamp_pos = v[7:0];
   endfunction

   // Zero and oversize grid values are pulled into range
   function automatic logic [8:0] grid_size(input logic [8:0] v);
      if (v == 9'd0)
         grid_size = GRID_MIN;
      else if (v > GRID_MAX)
         grid_size = GRID_MAX;
      else
         grid_size = v;
   endfunction

   assign ncols = grid_size(columns_ff);
   assign nrows = grid_size(rows_ff);

   // Handshakes: take a request only with room for two results
   assign req_stall = (count_ff > CNT_W'(FIFO_DEPTH - 2));
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_fire  = rsp_valid && !rsp_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
         rows_ff    <= ROWS_RESET;
         fg_ff      <= FG_RESET;
         bg_ff      <= BG_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_COLUMNS: columns_ff <= csr_wdata[8:0];
            REG_ROWS:    rows_ff    <= csr_wdata[8:0];
            REG_FG:      fg_ff      <= csr_wdata;
            REG_BG:      bg_ff      <= csr_wdata;
            default:     ;
         endcase
      end
   end

   // Cursor update and result building for the incoming request
   always_comb begin
      logic [8:0] col;
      logic [8:0] row;
      logic       drew;
      logic       scrolled;
      logic [7:0] dglyph;
      logic [8:0] rows_m1;

      col      = {1'b0, cursor_col_ff};
      row      = {1'b0, cursor_row_ff};
      drew     = 1'b0;
      scrolled = 1'b0;
      dglyph   = 8'd0;
      rows_m1  = nrows - 9'd1;
      push_two = 1'b0;
      first_entry  = '0;
      second_entry = '0;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;

      unique case (req_action)
         ACT_PUT_CHAR: begin
            // Control characters and glyph advance
            priority if (req_char_code == CHAR_NEWLINE) begin
               col = 9'd0;
               row = row + 9'd1;
            end else if (req_char_code == CHAR_RETURN) begin
               col = 9'd0;
            end else if (req_char_code == CHAR_TAB) begin
               col = (col + TAB_STEP) & TAB_MASK;
            end else if (req_char_code == CHAR_BACKSPACE) begin
               if (col != 9'd0) begin
                  col    = col - 9'd1;
                  drew   = 1'b1;
                  dglyph = CHAR_SPACE;
               end
            end else begin
               drew   = 1'b1;
               dglyph = req_char_code;
               col    = col + 9'd1;
            end
            // Line wrap, then scroll past the last line
            if (col >= ncols) begin
               col = 9'd0;
               row = row + 9'd1;
            end
            if (row >= nrows) begin
               row      = rows_m1;
               scrolled = 1'b1;
            end
            cursor_col_in = col[7:0];
            cursor_row_in = row[7:0];

            // Draw first (echo rides on it), scroll after
            if (drew) begin
               first_entry.command    = CMD_DRAW;
               first_entry.glyph      = dglyph;
               first_entry.cell_col   = (req_char_code == CHAR_BACKSPACE) ?
                                        cursor_col_ff - 8'd1 : cursor_col_ff;
               first_entry.cell_row   = cursor_row_ff;
               first_entry.draw_fg    = fg_ff;
               first_entry.draw_bg    = bg_ff;
               first_entry.echo_valid = 1'b1;
               first_entry.echo_byte  = req_char_code;
               if (scrolled) begin
                  push_two                = 1'b1;
                  second_entry.command    = CMD_SCROLL;
                  second_entry.cell_row   = rows_m1[7:0];
                  second_entry.draw_bg    = bg_ff;
               end
            end else if (scrolled) begin
               first_entry.command    = CMD_SCROLL;
               first_entry.cell_row   = rows_m1[7:0];
               first_entry.draw_bg    = bg_ff;
               first_entry.echo_valid = 1'b1;
               first_entry.echo_byte  = req_char_code;
            end else begin
               first_entry.command    = CMD_NONE;
               first_entry.echo_valid = 1'b1;
               first_entry.echo_byte  = req_char_code;
            end
         end
         ACT_SET_CURSOR: begin
            cursor_col_in = clamp_pos(req_target_col, ncols);
            cursor_row_in = clamp_pos(req_target_row, nrows);
            first_entry.command = CMD_NONE;
         end
         ACT_CLEAR: begin
            cursor_col_in = 8'd0;
            cursor_row_in = 8'd0;
            first_entry.command = CMD_CLEAR;
            first_entry.draw_bg = bg_ff;
         end
         ACT_RESERVED: begin
            first_entry.command = CMD_NONE;
         end
         default: ;
      endcase

      // Cursor position after the whole request, last marks the final result
      first_entry.cursor_col_now  = cursor_col_in;
      first_entry.cursor_row_now  = cursor_row_in;
      first_entry.last            = !push_two;
      second_entry.cursor_col_now = cursor_col_in;
      second_entry.cursor_row_now = cursor_row_in;
      second_entry.last           = 1'b1;
   end

   // Queue pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_fire) begin
         wr_ptr_in = wr_ptr_ff + (push_two ? PTR_W'(2) : PTR_W'(1));
         count_in  = count_in + (push_two ? CNT_W'(2) : CNT_W'(1));
      end
      if (rsp_fire) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
         count_in  = count_in - CNT_W'(1);
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= 8'd0;
         cursor_row_ff <= 8'd0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (req_fire) begin
            cursor_col_ff <= cursor_col_in;
            cursor_row_ff <= cursor_row_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (req_fire) begin
         fifo_ff[wr_ptr_ff] <= first_entry;
         if (push_two)
            fifo_ff[wr_ptr_ff + PTR_W'(1)] <= second_entry;
      end
   end

   // Result port
   assign head               = fifo_ff[rd_ptr_ff];
   assign rsp_command        = head.command;
   assign rsp_glyph          = head.glyph;
   assign rsp_cell_col       = head.cell_col;
   assign rsp_cell_row       = head.cell_row;
   assign rsp_draw_fg        = head.draw_fg;
   assign rsp_draw_bg        = head.draw_bg;
   assign rsp_echo_valid     = head.echo_valid;
   assign rsp_echo_byte      = head.echo_byte;
   assign rsp_cursor_col_now = head.cursor_col_now;
   assign rsp_cursor_row_now = head.cursor_row_now;
   assign rsp_last           = head.last;

   // Terms used by the checks
   assign clear_fire     = req_fire && (req_action == ACT_CLEAR);
   assign put_fire       = req_fire && (req_action == ACT_PUT_CHAR) && !csr_wr_en;
   assign cursor_home    = (cursor_col_ff == 8'd0) && (cursor_row_ff == 8'd0);
   assign cursor_on_grid = ({1'b0, cursor_col_ff} < ncols) &&
                           ({1'b0, cursor_row_ff} < nrows);

   // Checks
   `TCCC_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(FIFO_DEPTH), "result queue overflow")
   `TCCC_ASSERT_NEXT(a_clear_home, clear_fire, cursor_home, "clear did not home the cursor")
   `TCCC_ASSERT_NEXT(a_put_on_grid, put_fire, cursor_on_grid, "cursor left the grid")

endmodule

### sim/text_console_cursor_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// Text console cursor controller testbench
// Runs directed and random requests through the controller. Each expected
// draw, scroll, clear or plain cursor result is worked out by a cycle-free
// model of the cursor and grid, then compared field by field as the results
// leave the block. Both channels see random gaps and stalls. One long output
// hold-off lets the result queue fill until the request side stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cursor_controller_unit_tb;
   import tccc_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [1:0]         csr_index;
   logic [31:0]        csr_wdata;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_action;
   logic [7:0]         req_char_code;
   logic signed [15:0] req_target_col;
   logic signed [15:0] req_target_row;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_command;
   logic [7:0]         rsp_glyph;
   logic [7:0]         rsp_cell_col;
   logic [7:0]         rsp_cell_row;
   logic [31:0]        rsp_draw_fg;
   logic [31:0]        rsp_draw_bg;
   logic               rsp_echo_valid;
   logic [7:0]         rsp_echo_byte;
   logic [7:0]         rsp_cursor_col_now;
   logic [7:0]         rsp_cursor_row_now;
   logic               rsp_last;

   // Model copy of the registers and the cursor
   logic [8:0]  grid_columns;
   logic [8:0]  grid_rows;
   logic [31:0] ink_colour;
   logic [31:0] paper_colour;
   logic [7:0]  cursor_col;
   logic [7:0]  cursor_row;

   rsp_entry_type pending_commands[$];
   int            mismatch_count = 0;
   int            cycle_count = 0;
   bit            sender_calm = 1'b0;
   int            holdoff_request = 0;

   text_console_cursor_controller_unit uut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_char_code      (req_char_code),
      .req_target_col     (req_target_col),
      .req_target_row     (req_target_row),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_command        (rsp_command),
      .rsp_glyph          (rsp_glyph),
      .rsp_cell_col       (rsp_cell_col),
      .rsp_cell_row       (rsp_cell_row),
      .rsp_draw_fg        (rsp_draw_fg),
      .rsp_draw_bg        (rsp_draw_bg),
      .rsp_echo_valid     (rsp_echo_valid),
      .rsp_echo_byte      (rsp_echo_byte),
      .rsp_cursor_col_now (rsp_cursor_col_now),
      .rsp_cursor_row_now (rsp_cursor_row_now),
      .rsp_last           (rsp_last)
   );

   always #4 clock = ~clock;

   // Run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[text_console_cursor_controller_unit] ERROR");
         $finish;
      end
   end

   // Effective grid size: zero reads as one, anything past the maximum saturates
   function automatic int unsigned grid_limit(logic [8:0] value);
      if (value < GRID_MIN) return 1;
      if (value > GRID_MAX) return 256;
      return value;
   endfunction

   function automatic logic [7:0] clamp_cell(logic signed [15:0] target, int unsigned size);
      int pos;
      pos = target;
      if (pos < 0) return 8'd0;
      if (pos >= int'(size)) return 8'(size - 1);
      return pos[7:0];
   endfunction

   // Mostly back-to-back, sometimes short gaps, now and then a long one
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Work out the commands one accepted request yields and queue them
   task automatic predict_console_commands(input logic [1:0] action, input logic [7:0] ch,
                                           input logic signed [15:0] tcol,
                                           input logic signed [15:0] trow);
      rsp_entry_type res[2];
      int unsigned   ncols, nrows, col, row;
      int            n;
      bit            drew, scrolled;
      logic [7:0]    dglyph, dcol, drow;
      ncols = grid_limit(grid_columns);
      nrows = grid_limit(grid_rows);
      res[0] = '0;
      res[1] = '0;
      n = 0;
      drew = 1'b0;
      scrolled = 1'b0;
      dglyph = '0;
      dcol = '0;
      drow = '0;
      case (action)
         ACT_PUT_CHAR: begin
            col = cursor_col;
            row = cursor_row;
            case (ch)
               CHAR_NEWLINE: begin
                  col = 0;
                  row++;
               end
               CHAR_RETURN: col = 0;
               CHAR_TAB: col = (col + TAB_STEP) & TAB_MASK;
               CHAR_BACKSPACE: begin
                  // erase the previous cell, nothing at the left margin
                  if (col > 0) begin
                     col--;
                     drew = 1'b1;
                     dglyph = CHAR_SPACE;
                     dcol = col[7:0];
                     drow = row[7:0];
                  end
               end
               default: begin
                  drew = 1'b1;
                  dglyph = ch;
                  dcol = col[7:0];
                  drow = row[7:0];
                  col++;
               end
            endcase
            if (col >= ncols) begin
               col = 0;
               row++;
            end
            if (row >= nrows) begin
               row = nrows - 1;
               scrolled = 1'b1;
            end
            cursor_col = col[7:0];
            cursor_row = row[7:0];
            if (drew) begin
               res[n].command    = CMD_DRAW;
               res[n].glyph      = dglyph;
               res[n].cell_col   = dcol;
               res[n].cell_row   = drow;
               res[n].draw_fg    = ink_colour;
               res[n].draw_bg    = paper_colour;
               res[n].echo_valid = 1'b1;
               res[n].echo_byte  = ch;
               n++;
            end
            if (scrolled) begin
               res[n].command    = CMD_SCROLL;
               res[n].cell_row   = 8'(nrows - 1);
               res[n].draw_bg    = paper_colour;
               res[n].echo_valid = (n == 0);
               res[n].echo_byte  = (n == 0) ? ch : 8'd0;
               n++;
            end
            if (n == 0) begin
               res[0].command    = CMD_NONE;
               res[0].echo_valid = 1'b1;
               res[0].echo_byte  = ch;
               n = 1;
            end
         end
         ACT_SET_CURSOR: begin
            cursor_col = clamp_cell(tcol, ncols);
            cursor_row = clamp_cell(trow, nrows);
            res[0].command = CMD_NONE;
            n = 1;
         end
         ACT_CLEAR: begin
            cursor_col = '0;
            cursor_row = '0;
            res[0].command = CMD_CLEAR;
            res[0].draw_bg = paper_colour;
            n = 1;
         end
         default: begin
            res[0].command = CMD_NONE;
            n = 1;
         end
      endcase
      for (int k = 0; k < n; k++) begin
         res[k].cursor_col_now = cursor_col;
         res[k].cursor_row_now = cursor_row;
         res[k].last = (k == n - 1);
         pending_commands.push_back(res[k]);
      end
   endtask

   // Offer one request, hold it until taken, then predict its results
   task automatic send_request(input logic [1:0] action, input logic [7:0] ch,
                               input logic signed [15:0] tcol,
                               input logic signed [15:0] trow);
      int gap;
      gap = sender_calm ? 0 : idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_char_code  <= ch;
      req_target_col <= tcol;
      req_target_row <= trow;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_console_commands(action, ch, tcol, trow);
   endtask

   task automatic put_char(input logic [7:0] ch);
      send_request(ACT_PUT_CHAR, ch, 16'(int'($urandom)), 16'(int'($urandom)));
   endtask

   task automatic move_cursor(input int tcol, input int trow);
      send_request(ACT_SET_CURSOR, 8'($urandom), 16'(tcol), 16'(trow));
   endtask

   // Stop offering and let every outstanding result drain
   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_register(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         REG_COLUMNS: grid_columns = value[8:0];
         REG_ROWS:    grid_rows    = value[8:0];
         REG_FG:      ink_colour   = value;
         REG_BG:      paper_colour = value;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_screen(input logic [31:0] cols, input logic [31:0] rows,
                             input logic [31:0] fg, input logic [31:0] bg);
      wait_until_drained();
      program_register(REG_COLUMNS, cols);
      program_register(REG_ROWS, rows);
      program_register(REG_FG, fg);
      program_register(REG_BG, bg);
   endtask

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin : result_checker
      rsp_entry_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_commands.size() == 0) begin
            $error("result with nothing pending: command %0d", rsp_command);
            mismatch_count++;
         end else begin
            want = pending_commands.pop_front();
            compare_field("command", want.command, rsp_command);
            compare_field("glyph", want.glyph, rsp_glyph);
            compare_field("cell_col", want.cell_col, rsp_cell_col);
            compare_field("cell_row", want.cell_row, rsp_cell_row);
            compare_field("draw_fg", want.draw_fg, rsp_draw_fg);
            compare_field("draw_bg", want.draw_bg, rsp_draw_bg);
            compare_field("echo_valid", want.echo_valid, rsp_echo_valid);
            compare_field("echo_byte", want.echo_byte, rsp_echo_byte);
            compare_field("cursor_col_now", want.cursor_col_now, rsp_cursor_col_now);
            compare_field("cursor_row_now", want.cursor_row_now, rsp_cursor_row_now);
            compare_field("last", want.last, rsp_last);
         end
      end
   end

   // Result side stalls: random bursts, calm stretches and the requested hold-off
   initial begin : result_sink
      int stall_left;
      int calm_left;
      int pick;
      stall_left = 0;
      calm_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_request > 0) begin
            stall_left = holdoff_request;
            holdoff_request = 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (calm_left > 0) begin
            rsp_stall <= 1'b0;
            calm_left--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               calm_left = $urandom_range(20, 80);
               rsp_stall <= 1'b0;
            end else if (pick < 70) begin
               rsp_stall <= 1'b0;
            end else if (pick < 95) begin
               stall_left = $urandom_range(0, 2);
               rsp_stall <= 1'b1;
            end else begin
               stall_left = $urandom_range(9, 39);
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   // Reset values: 80 by 25, black on white; extreme byte values draw too
   task automatic test_reset_defaults();
      put_char("A");
      put_char(8'hFF);
      put_char(8'h00);
   endtask

   // Tab, backspace with erase, return, backspace at the margin, newline
   task automatic test_control_characters();
      put_char(CHAR_TAB);
      put_char(CHAR_BACKSPACE);
      put_char(CHAR_RETURN);
      put_char(CHAR_BACKSPACE);
      put_char(CHAR_NEWLINE);
   endtask

   // Clamping, wrap into scroll, tab wrap, the unused action and clear
   task automatic test_cursor_edges();
      move_cursor(-32768, -32768);
      move_cursor(32767, 32767);
      put_char(CHAR_NEWLINE);
      move_cursor(79, 24);
      put_char("Z");
      move_cursor(78, 0);
      put_char(CHAR_TAB);
      send_request(ACT_RESERVED, 8'hA5, 16'sh7FFF, -16'sd1);
      send_request(ACT_CLEAR, 8'h5A, -16'sd1, 16'sh7FFF);
   endtask

   // Zero-sized grid reads as one cell; oversized columns saturate at 256
   task automatic test_grid_extremes();
      set_screen(32'd0, 32'd0, 32'hFFFF_FFFF, 32'h0000_0000);
      put_char("x");
      put_char(CHAR_NEWLINE);
      set_screen(32'h1FF, 32'd256, $urandom, $urandom);
      move_cursor(300, 300);
      put_char("~");
   endtask

   // Cursor left outside the grid after it shrinks; backspace erases there too
   task automatic test_shrunk_grid();
      move_cursor(70, 20);
      set_screen(32'd10, 32'd5, 32'h0000_0000, 32'hFFFF_FFFF);
      put_char(CHAR_BACKSPACE);
      move_cursor(70, 20);
      set_screen(32'd10, 32'd5, 32'h0000_0000, 32'hFFFF_FFFF);
      put_char("q");
   endtask

   function automatic logic [7:0] random_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return 8'($urandom_range(8'h20, 8'h7E));
      if (pick < 60) return CHAR_NEWLINE;
      if (pick < 66) return CHAR_RETURN;
      if (pick < 74) return CHAR_TAB;
      if (pick < 84) return CHAR_BACKSPACE;
      return 8'($urandom);
   endfunction

   // Mostly near the grid edges, sometimes anywhere in the 16-bit range
   function automatic logic signed [15:0] random_target(logic [8:0] size_reg);
      int unsigned size;
      size = grid_limit(size_reg);
      if ($urandom_range(0, 3) != 0) return 16'(int'($urandom_range(0, size + 3)) - 2);
      return 16'($urandom);
   endfunction

   task automatic send_random_request();
      int         pick;
      logic [1:0] action;
      pick = $urandom_range(0, 99);
      if (pick < 70)      action = ACT_PUT_CHAR;
      else if (pick < 88) action = ACT_SET_CURSOR;
      else if (pick < 95) action = ACT_CLEAR;
      else                action = ACT_RESERVED;
      send_request(action, random_char(), random_target(grid_columns),
                   random_target(grid_rows));
   endtask

   // Long result hold-off while requests keep coming, so the queue backs up
   task automatic test_output_holdoff();
      sender_calm = 1'b1;
      holdoff_request = 300;
      repeat (20) send_random_request();
      sender_calm = 1'b0;
   endtask

   // Random traffic over a spread of grid sizes and colours
   task automatic test_random_traffic();
      logic [31:0] cols, rows, fg, bg;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin cols = 80; rows = 25; end
            1: begin cols = 1; rows = 1; end
            2: begin cols = 256; rows = 256; end
            3: begin cols = 4; rows = 3; end
            4: begin cols = $urandom_range(1, 16); rows = $urandom_range(1, 16); end
            5: begin cols = $urandom_range(257, 511); rows = $urandom_range(0, 8); end
            6: begin cols = 0; rows = $urandom_range(2, 40); end
            default: begin
               // upper bits beyond the 9-bit size field are dropped
               cols = {$urandom} << 9 | $urandom_range(0, 511);
               rows = {$urandom} << 9 | $urandom_range(0, 511);
            end
         endcase
         fg = (phase == 1) ? 32'hFFFF_FFFF : $urandom;
         bg = (phase == 1) ? 32'h0000_0000 : $urandom;
         set_screen(cols, rows, fg, bg);
         for (int i = 0; i < 150; i++) begin
            if (i % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
            send_random_request();
         end
         sender_calm = 1'b0;
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = REG_COLUMNS;
      csr_wdata      = '0;
      req_valid      = 1'b0;
      req_action     = ACT_PUT_CHAR;
      req_char_code  = '0;
      req_target_col = '0;
      req_target_row = '0;
      grid_columns   = COLUMNS_RESET;
      grid_rows      = ROWS_RESET;
      ink_colour     = FG_RESET;
      paper_colour   = BG_RESET;
      cursor_col     = '0;
      cursor_row     = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_control_characters();
      test_cursor_edges();
      test_grid_extremes();
      test_shrunk_grid();
      test_output_holdoff();
      test_random_traffic();

      // Drain, then watch a little longer for stray results
      wait_until_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("[text_console_cursor_controller_unit] OK");
      else
         $display("[text_console_cursor_controller_unit] ERROR");
      $finish;
   end

endmodule

### files.f
+incdir+hdl
hdl/tccc_pkg.sv
hdl/text_console_cursor_controller_unit.sv
sim/text_console_cursor_controller_unit_tb.sv
